// ----- hw/rtl/tqp_pkg.sv -----
// Shared types and constants for the tone queue player.
package tqp_pkg;

   localparam int QUEUE_DEPTH = 32;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam int CLK_W    = 26;
   localparam int PERIOD_W = 25;
   localparam int DUR_W    = 16;
   localparam int FREQ_W   = 16;
   localparam int DIV_W    = FREQ_W + 1;
   localparam int STEP_W   = $clog2(CLK_W);

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_IDX_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam logic [CLK_W-1:0] CLOCK_HZ_RESET = CLK_W'(12500000);

   localparam logic ACT_ADD  = 1'b0;
   localparam logic ACT_TICK = 1'b1;

   typedef struct packed {
      logic                action;
      logic [DUR_W-1:0]    duration;
      logic [PERIOD_W-1:0] period;
      logic                count_enable;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef struct packed {
      logic                started;
      logic [PERIOD_W-1:0] period;
      logic [DUR_W-1:0]    duration;
   } entry_type;

   typedef struct packed {
      logic                accepted;
      logic                timer_running;
      logic [PERIOD_W-1:0] timer_period;
      logic                timer_restart;
      logic                pin_cleared;
      logic                busy_res;
   } rsp_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_DIV,
      F_DONE
   } front_state_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_READ,
      B_EXEC
   } back_state_type;

endpackage

// ----- hw/rtl/tqp_front.sv -----
// Front end: takes words, computes tone periods with a serial divider, feeds the queue.
module tqp_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_action,
   input  logic [tqp_pkg::DUR_W-1:0]    req_duration_ms,
   input  logic [tqp_pkg::FREQ_W-1:0]   req_freq_hz,
   input  logic                         req_count_enable,
   input  logic [tqp_pkg::CLK_W-1:0]    clock_hz,
   input  tqp_pkg::queue_status_type    q_status,
   output logic                         push,
   output tqp_pkg::cmd_type             push_cmd
);

   tqp_pkg::front_state_type state_ff, state_in;
   logic [tqp_pkg::CLK_W-1:0]  quot_ff, quot_in;
   logic [tqp_pkg::DIV_W-1:0]  rem_ff, rem_in;
   logic [tqp_pkg::DIV_W-1:0]  divisor_ff, divisor_in;
   logic [tqp_pkg::STEP_W-1:0] step_ff, step_in;
   logic [tqp_pkg::DUR_W-1:0]  dur_ff, dur_in;

   logic                       take;
   logic [tqp_pkg::DIV_W:0]    trial;
   logic                       fits;

   assign busy  = (state_ff != tqp_pkg::F_IDLE) || q_status.full;
   assign take  = start && !busy;
   assign trial = {rem_ff, quot_ff[tqp_pkg::CLK_W-1]};
   assign fits  = trial >= {1'b0, divisor_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tqp_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      step_ff    <= step_in;
      dur_ff     <= dur_in;
   end

   always_comb begin
      state_in   = state_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      step_in    = step_ff;
      dur_in     = dur_ff;
      push       = 1'b0;
      push_cmd   = '0;
      case (state_ff)
         tqp_pkg::F_IDLE: begin
            if (take) begin
               if (req_action == tqp_pkg::ACT_TICK || req_freq_hz == '0) begin
                  push                  = 1'b1;
                  push_cmd.action       = req_action;
                  push_cmd.duration     = req_duration_ms;
                  push_cmd.period       = '0;
                  push_cmd.count_enable = req_count_enable;
               end else begin
                  quot_in    = clock_hz;
                  rem_in     = '0;
                  divisor_in = {req_freq_hz, 1'b0};
                  step_in    = '0;
                  dur_in     = req_duration_ms;
                  state_in   = tqp_pkg::F_DIV;
               end
            end
         end
         tqp_pkg::F_DIV: begin
            if (fits) begin
               rem_in = tqp_pkg::DIV_W'(trial - {1'b0, divisor_ff});
            end else begin
               rem_in = trial[tqp_pkg::DIV_W-1:0];
            end
            quot_in = {quot_ff[tqp_pkg::CLK_W-2:0], fits};
            step_in = step_ff + 1'b1;
            if (step_ff == tqp_pkg::STEP_W'(tqp_pkg::CLK_W - 1)) begin
               state_in = tqp_pkg::F_DONE;
            end
         end
         tqp_pkg::F_DONE: begin
            push              = 1'b1;
            push_cmd.action   = tqp_pkg::ACT_ADD;
            push_cmd.duration = dur_ff;
            if (quot_ff == '0) begin
               push_cmd.period = '0;
            end else begin
               push_cmd.period = tqp_pkg::PERIOD_W'(quot_ff - 1'b1);
            end
            push_cmd.count_enable = 1'b0;
            state_in              = tqp_pkg::F_IDLE;
         end
         default: begin
            state_in = tqp_pkg::F_IDLE;
         end
      endcase
   end

endmodule

// ----- hw/rtl/tqp_queue.sv -----
// Short command queue between the front end and the player.
module tqp_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  tqp_pkg::cmd_type          push_cmd,
   input  logic                      pop,
   output tqp_pkg::cmd_type          head_cmd,
   output tqp_pkg::queue_status_type status
);

   tqp_pkg::cmd_type slots_ff [tqp_pkg::FIFO_DEPTH];
   logic [tqp_pkg::FIFO_IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [tqp_pkg::FIFO_IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [tqp_pkg::FIFO_CNT_W-1:0] count_ff, count_in;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == tqp_pkg::FIFO_CNT_W'(tqp_pkg::FIFO_DEPTH));
   assign head_cmd     = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- hw/rtl/tqp_back.sv -----
// Player: holds the tone memory and carries out add and tick commands.
module tqp_back (
   input  logic                      clock,
   input  logic                      reset,
   input  tqp_pkg::queue_status_type q_status,
   input  tqp_pkg::cmd_type          head_cmd,
   output logic                      pop,
   output logic                      rsp_strobe,
   output tqp_pkg::rsp_type          rsp
);

   tqp_pkg::entry_type mem [tqp_pkg::QUEUE_DEPTH];

   tqp_pkg::back_state_type state_ff, state_in;
   tqp_pkg::cmd_type              cmd_ff, cmd_in;
   tqp_pkg::entry_type            rd_ff;
   logic [tqp_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [tqp_pkg::IDX_W-1:0]     idx_ff, idx_in;
   logic                          on_ff, on_in;
   logic [tqp_pkg::PERIOD_W-1:0]  loaded_ff, loaded_in;
   logic                          strobe_ff, strobe_in;
   tqp_pkg::rsp_type              rsp_ff, rsp_in;

   logic                          wr_en;
   logic [tqp_pkg::IDX_W-1:0]     wr_addr;
   tqp_pkg::entry_type            wr_data;
   logic [tqp_pkg::CNT_W-1:0]     idx_next;
   logic                          accepted;
   logic                          restart;
   logic                          pin;

   assign idx_next   = tqp_pkg::CNT_W'(idx_ff) + 1'b1;
   assign rsp_strobe = strobe_ff;
   assign rsp        = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= tqp_pkg::B_IDLE;
         count_ff  <= '0;
         idx_ff    <= '0;
         on_ff     <= 1'b0;
         loaded_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         idx_ff    <= idx_in;
         on_ff     <= on_in;
         loaded_ff <= loaded_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= mem[idx_ff];
   end

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      on_in     = on_ff;
      loaded_in = loaded_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      pop       = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = idx_ff;
      wr_data   = rd_ff;
      accepted  = 1'b0;
      restart   = 1'b0;
      pin       = 1'b0;
      case (state_ff)
         tqp_pkg::B_IDLE: begin
            if (!q_status.empty) begin
               pop      = 1'b1;
               cmd_in   = head_cmd;
               state_in = tqp_pkg::B_READ;
            end
         end
         tqp_pkg::B_READ: begin
            state_in = tqp_pkg::B_EXEC;
         end
         tqp_pkg::B_EXEC: begin
            if (cmd_ff.action == tqp_pkg::ACT_ADD) begin
               if (count_ff < tqp_pkg::CNT_W'(tqp_pkg::QUEUE_DEPTH)) begin
                  wr_en            = 1'b1;
                  wr_addr          = count_ff[tqp_pkg::IDX_W-1:0];
                  wr_data.started  = 1'b0;
                  wr_data.period   = cmd_ff.period;
                  wr_data.duration = cmd_ff.duration;
                  count_in         = count_ff + 1'b1;
                  accepted         = 1'b1;
               end
            end else if (count_ff != '0) begin
               if (rd_ff.started) begin
                  if (rd_ff.duration == '0) begin
                     if (idx_next >= count_ff) begin
                        idx_in   = '0;
                        count_in = '0;
                        on_in    = 1'b0;
                        pin      = 1'b1;
                     end else begin
                        idx_in = idx_next[tqp_pkg::IDX_W-1:0];
                     end
                  end else if (cmd_ff.count_enable) begin
                     wr_en            = 1'b1;
                     wr_data.duration = rd_ff.duration - 1'b1;
                  end
               end else begin
                  pin = 1'b1;
                  if (rd_ff.period != '0) begin
                     restart   = 1'b1;
                     loaded_in = rd_ff.period;
                     on_in     = 1'b1;
                  end else begin
                     on_in = 1'b0;
                  end
                  wr_en           = 1'b1;
                  wr_data.started = 1'b1;
               end
            end
            strobe_in            = 1'b1;
            rsp_in.accepted      = accepted;
            rsp_in.timer_running = on_in;
            rsp_in.timer_period  = loaded_in;
            rsp_in.timer_restart = restart;
            rsp_in.pin_cleared   = pin;
            rsp_in.busy_res      = (count_in != '0);
            state_in             = tqp_pkg::B_IDLE;
         end
         default: begin
            state_in = tqp_pkg::B_IDLE;
         end
      endcase
   end

endmodule

// ----- hw/rtl/tone_queue_player.sv -----
// Top level of the tone queue player: clock register, front end, queue and player.
//
// Usage: a word is taken when start is high and busy is low. req_action 0 adds
// a tone (req_duration_ms, req_freq_hz); 1 is one player tick (req_count_enable).
// Every word gives exactly one result word, shown for one cycle with rsp_valid
// high; results come out in the order the words were taken. The receiver has
// no way to stall, so the block never waits on the result side.
// A tick or silent add is pushed into the queue in the cycle it is taken; the
// player pops it, reads the tone memory, executes it and registers rsp_valid.
// A nonzero-frequency add first runs the period divider, one quotient bit a
// cycle. Throughput: the front end takes one word per cycle until the 4-deep
// command queue fills; a tone add holds busy while it divides, and the player
// pops a word only after executing the last.
// csr_we/csr_wdata write the timer clock rate; write it only while idle.
// Reset (synchronous, active high) empties the queue, stops the timer, clears
// the loaded period and sets the clock rate to 12.5 MHz. No clearing pass.
module tone_queue_player (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_action,
   input  logic [tqp_pkg::DUR_W-1:0]     req_duration_ms,
   input  logic [tqp_pkg::FREQ_W-1:0]    req_freq_hz,
   input  logic                          req_count_enable,
   output logic                          rsp_valid,
   output logic                          rsp_accepted,
   output logic                          rsp_timer_running,
   output logic [tqp_pkg::PERIOD_W-1:0]  rsp_timer_period,
   output logic                          rsp_timer_restart,
   output logic                          rsp_pin_cleared,
   output logic                          rsp_busy_res,
   input  logic                          csr_we,
   input  logic [tqp_pkg::CLK_W-1:0]     csr_wdata
);

   logic [tqp_pkg::CLK_W-1:0] clock_hz_ff, clock_hz_in;

   tqp_pkg::queue_status_type q_status;
   tqp_pkg::cmd_type          push_cmd;
   tqp_pkg::cmd_type          head_cmd;
   tqp_pkg::rsp_type          rsp;
   logic                      push;
   logic                      pop;

   assign clock_hz_in = csr_we ? csr_wdata : clock_hz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_hz_ff <= tqp_pkg::CLOCK_HZ_RESET;
      end else begin
         clock_hz_ff <= clock_hz_in;
      end
   end

   tqp_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_duration_ms  (req_duration_ms),
      .req_freq_hz      (req_freq_hz),
      .req_count_enable (req_count_enable),
      .clock_hz         (clock_hz_ff),
      .q_status         (q_status),
      .push             (push),
      .push_cmd         (push_cmd)
   );

   tqp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   tqp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_strobe (rsp_valid),
      .rsp        (rsp)
   );

   assign rsp_accepted      = rsp.accepted;
   assign rsp_timer_running = rsp.timer_running;
   assign rsp_timer_period  = rsp.timer_period;
   assign rsp_timer_restart = rsp.timer_restart;
   assign rsp_pin_cleared   = rsp.pin_cleared;
   assign rsp_busy_res      = rsp.busy_res;

   a_restart_runs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_timer_restart |-> rsp_timer_running && rsp_pin_cleared)
      else $error("timer restart without running timer");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> rsp_busy_res)
      else $error("stored tone but queue reported empty");

   a_pin_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pin_cleared |-> !rsp_timer_running || rsp_timer_restart)
      else $error("pin cleared while timer kept running");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held over two cycles");

endmodule

// ----- tb/testbench.sv -----
// Testbench for tone_queue_player: scoreboard with a tone queue predictor, directed and random words.
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned CYCLE_LIMIT  = 600000;
   localparam int unsigned RANDOM_WORDS = 1150;

   class tone_scoreboard;
      logic [tqp_pkg::CLK_W-1:0]    clock_hz;
      logic [tqp_pkg::DUR_W-1:0]    tone_dur [tqp_pkg::QUEUE_DEPTH];
      logic [tqp_pkg::PERIOD_W-1:0] tone_per [tqp_pkg::QUEUE_DEPTH];
      bit                           tone_started [tqp_pkg::QUEUE_DEPTH];
      int unsigned                  queue_count;
      int unsigned                  play_index;
      bit                           timer_on;
      logic [tqp_pkg::PERIOD_W-1:0] loaded_period;
      tqp_pkg::rsp_type             pending_rsps[$];
      int unsigned                  mismatches;

      function new();
         clock_hz      = tqp_pkg::CLOCK_HZ_RESET;
         queue_count   = 0;
         play_index    = 0;
         timer_on      = 0;
         loaded_period = '0;
         mismatches    = 0;
         foreach (tone_dur[i]) begin
            tone_dur[i]     = '0;
            tone_per[i]     = '0;
            tone_started[i] = 0;
         end
      endfunction

      function logic [tqp_pkg::PERIOD_W-1:0] period_of(logic [tqp_pkg::FREQ_W-1:0] freq);
         longint unsigned quot;
         if (freq == 0)
            return '0;
         quot = 64'(clock_hz) / (64'(freq) * 64'd2);
         if (quot == 0)
            return '0;
         return tqp_pkg::PERIOD_W'(quot - 1);
      endfunction

      // advance the player on one accepted word and queue its result
      function void note_word(logic act, logic [tqp_pkg::DUR_W-1:0] dur,
                              logic [tqp_pkg::FREQ_W-1:0] freq, logic ce);
         tqp_pkg::rsp_type exp_rsp;
         int unsigned      idx;
         exp_rsp = '0;
         if (act == tqp_pkg::ACT_ADD) begin
            if (queue_count < tqp_pkg::QUEUE_DEPTH) begin
               tone_started[queue_count] = 0;
               tone_dur[queue_count]     = dur;
               tone_per[queue_count]     = period_of(freq);
               queue_count++;
               exp_rsp.accepted = 1'b1;
            end
         end else if (queue_count > 0) begin
            idx = play_index;
            if (tone_started[idx]) begin
               if (tone_dur[idx] == 0) begin
                  play_index++;
                  if (play_index >= queue_count) begin
                     play_index  = 0;
                     queue_count = 0;
                     timer_on    = 0;
                     exp_rsp.pin_cleared = 1'b1;
                  end
               end else if (ce) begin
                  tone_dur[idx] = tone_dur[idx] - 1'b1;
               end
            end else begin
               exp_rsp.pin_cleared = 1'b1;
               if (tone_per[idx] != 0) begin
                  exp_rsp.timer_restart = 1'b1;
                  loaded_period = tone_per[idx];
                  timer_on      = 1;
               end else begin
                  timer_on = 0;
               end
               tone_started[idx] = 1;
            end
         end
         exp_rsp.timer_running = timer_on;
         exp_rsp.timer_period  = loaded_period;
         exp_rsp.busy_res      = (queue_count > 0);
         pending_rsps.push_back(exp_rsp);
      endfunction

      function string show(tqp_pkg::rsp_type r);
         return $sformatf("acc=%0d run=%0d period=%0d restart=%0d pin=%0d busy=%0d",
                          r.accepted, r.timer_running, r.timer_period,
                          r.timer_restart, r.pin_cleared, r.busy_res);
      endfunction

      function void check_word(tqp_pkg::rsp_type got_rsp);
         tqp_pkg::rsp_type exp_rsp;
         if (pending_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result word: %s", show(got_rsp));
            return;
         end
         exp_rsp = pending_rsps.pop_front();
         if (got_rsp.accepted !== exp_rsp.accepted ||
             got_rsp.timer_running !== exp_rsp.timer_running ||
             got_rsp.timer_period !== exp_rsp.timer_period ||
             got_rsp.timer_restart !== exp_rsp.timer_restart ||
             got_rsp.pin_cleared !== exp_rsp.pin_cleared ||
             got_rsp.busy_res !== exp_rsp.busy_res) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result mismatch at %0t: expected %s, got %s", $realtime,
                        show(exp_rsp), show(got_rsp));
         end
      endfunction
   endclass

   logic                         clock;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic                         req_action;
   logic [tqp_pkg::DUR_W-1:0]    req_duration_ms;
   logic [tqp_pkg::FREQ_W-1:0]   req_freq_hz;
   logic                         req_count_enable;
   logic                         rsp_valid;
   logic                         rsp_accepted;
   logic                         rsp_timer_running;
   logic [tqp_pkg::PERIOD_W-1:0] rsp_timer_period;
   logic                         rsp_timer_restart;
   logic                         rsp_pin_cleared;
   logic                         rsp_busy_res;
   logic                         csr_we;
   logic [tqp_pkg::CLK_W-1:0]    csr_wdata;
   tqp_pkg::rsp_type             seen_rsp;

   tone_scoreboard      sb;
   int unsigned         cycle_count = 0;
   int unsigned         words_sent;
   int unsigned         burst_left;
   int unsigned         rate_writes;

   tone_queue_player uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_duration_ms   (req_duration_ms),
      .req_freq_hz       (req_freq_hz),
      .req_count_enable  (req_count_enable),
      .rsp_valid         (rsp_valid),
      .rsp_accepted      (rsp_accepted),
      .rsp_timer_running (rsp_timer_running),
      .rsp_timer_period  (rsp_timer_period),
      .rsp_timer_restart (rsp_timer_restart),
      .rsp_pin_cleared   (rsp_pin_cleared),
      .rsp_busy_res      (rsp_busy_res),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata)
   );

   assign seen_rsp = {rsp_accepted, rsp_timer_running, rsp_timer_period,
                      rsp_timer_restart, rsp_pin_cleared, rsp_busy_res};

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_word(seen_rsp);
   end

   function automatic logic [tqp_pkg::FREQ_W-1:0] next_freq();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return tqp_pkg::FREQ_W'($urandom_range(1, 1000));
         2: return tqp_pkg::FREQ_W'($urandom_range(30000, 65535));
         default: return tqp_pkg::FREQ_W'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [tqp_pkg::DUR_W-1:0] next_duration();
      case ($urandom_range(0, 19))
         0: return tqp_pkg::DUR_W'($urandom_range(4, 200));
         1, 2: return tqp_pkg::DUR_W'($urandom_range(4, 15));
         default: return tqp_pkg::DUR_W'($urandom_range(0, 3));
      endcase
   endfunction

   function automatic logic [tqp_pkg::CLK_W-1:0] next_clock_rate();
      case (rate_writes)
         0: return tqp_pkg::CLK_W'(1000);
         1: return '0;
         2: return tqp_pkg::CLK_W'(50000000);
         3: return '1;
         4: return tqp_pkg::CLOCK_HZ_RESET;
         default: return tqp_pkg::CLK_W'($urandom_range(1000, 50000000));
      endcase
   endfunction

   task automatic send_word(input logic act, input logic [tqp_pkg::DUR_W-1:0] dur,
                            input logic [tqp_pkg::FREQ_W-1:0] freq, input logic ce);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            @(negedge clock);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      @(negedge clock);
      start            <= 1'b1;
      req_action       <= act;
      req_duration_ms  <= dur;
      req_freq_hz      <= freq;
      req_count_enable <= ce;
      do
         @(posedge clock);
      while (busy);
      sb.note_word(act, dur, freq, ce);
      words_sent++;
      burst_left--;
   endtask

   task automatic send_add(input logic [tqp_pkg::DUR_W-1:0] dur,
                           input logic [tqp_pkg::FREQ_W-1:0] freq);
      send_word(tqp_pkg::ACT_ADD, dur, freq, logic'($urandom_range(0, 1)));
   endtask

   task automatic send_tick(input logic ce);
      send_word(tqp_pkg::ACT_TICK, tqp_pkg::DUR_W'($urandom_range(0, 65535)),
                tqp_pkg::FREQ_W'($urandom_range(0, 65535)), ce);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (sb.pending_rsps.size() != 0)
         @(posedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_clock_rate(input logic [tqp_pkg::CLK_W-1:0] rate);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= rate;
      @(posedge clock);
      sb.clock_hz = rate;
      rate_writes++;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      int unsigned n_adds;
      int unsigned guard;
      int unsigned phase;
      sb               = new();
      words_sent       = 0;
      burst_left       = 0;
      rate_writes      = 0;
      reset            = 1'b1;
      start            = 1'b0;
      req_action       = tqp_pkg::ACT_ADD;
      req_duration_ms  = '0;
      req_freq_hz      = '0;
      req_count_enable = 1'b0;
      csr_we           = 1'b0;
      csr_wdata        = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty tick, silence, zero duration, extremes of frequency
      send_word(tqp_pkg::ACT_TICK, '1, '1, 1'b1);
      send_word(tqp_pkg::ACT_ADD, '0, '0, 1'b1);
      send_word(tqp_pkg::ACT_ADD, tqp_pkg::DUR_W'(2), tqp_pkg::FREQ_W'(1), 1'b0);
      send_word(tqp_pkg::ACT_ADD, tqp_pkg::DUR_W'(1), '1, 1'b1);
      send_word(tqp_pkg::ACT_ADD, '0, tqp_pkg::FREQ_W'(440), 1'b0);
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b1);
      write_clock_rate(next_clock_rate());
      // slow timer clock: frequencies above a quarter of the clock go silent
      send_word(tqp_pkg::ACT_ADD, tqp_pkg::DUR_W'(1), tqp_pkg::FREQ_W'(501), 1'b1);
      send_word(tqp_pkg::ACT_ADD, '0, tqp_pkg::FREQ_W'(250), 1'b1);
      send_word(tqp_pkg::ACT_ADD, '0, tqp_pkg::FREQ_W'(1), 1'b1);
      repeat (7) send_tick(1'b1);

      phase = 0;
      while (words_sent < RANDOM_WORDS + 25) begin
         if (phase % 2 == 1)
            write_clock_rate(next_clock_rate());
         n_adds = ($urandom_range(0, 6) == 0) ? $urandom_range(30, 38) : $urandom_range(1, 12);
         repeat (n_adds) begin
            if ($urandom_range(0, 9) == 0)
               send_tick(logic'($urandom_range(0, 1)));
            else if (sb.queue_count >= tqp_pkg::QUEUE_DEPTH)
               send_add(tqp_pkg::DUR_W'($urandom_range(0, 65535)),
                        tqp_pkg::FREQ_W'($urandom_range(0, 65535)));
            else
               send_add(next_duration(), next_freq());
         end
         guard = 0;
         while (sb.queue_count > 0 && guard < 800) begin
            if ($urandom_range(0, 11) == 0)
               send_add(next_duration(), next_freq());
            else
               send_tick(logic'($urandom_range(0, 4) != 0));
            guard++;
         end
         repeat ($urandom_range(0, 3)) send_tick(logic'($urandom_range(0, 1)));
         phase++;
      end

      @(negedge clock);
      start <= 1'b0;
      while (sb.pending_rsps.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_rsps.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
